// ----- sv/rlhd_pkg.sv -----
`timescale 1ns / 1ps

package rlhd_pkg;

	localparam int FIELD_W  = 20;
	localparam int STATUS_W = 2;

	typedef logic [FIELD_W-1:0]  field_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Status codes
	localparam status_t STATUS_DRY      = 2'd0;
	localparam status_t STATUS_STARTED  = 2'd1;
	localparam status_t STATUS_RAINING  = 2'd2;
	localparam status_t STATUS_ENDED    = 2'd3;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_THRESHOLD_RAIN = 1'd0;
	localparam cfg_index_t REG_THRESHOLD_DRY  = 1'd1;

	localparam field_t THRESHOLD_RAIN_RESET = 20'd620;
	localparam field_t THRESHOLD_DRY_RESET  = 20'd590;

	// Thresholds as seen by the classifier
	typedef struct packed {
		field_t rain;
		field_t dry;
	} thresholds_t;

endpackage

// ----- sv/rain_level_hysteresis_detector.sv -----
`timescale 1ns / 1ps

// Rain level detector with hysteresis. Each item carries one capacitor charge
// time; the block keeps the last WINDOW_LEN times in a chain of cells, updates
// a running sum, forms the truncated mean and classifies it: status 0 dry,
// 1 rain started (mean above threshold_rain while dry), 2 raining, 3 rain
// ended (mean below threshold_dry while wet). rain_indicator is set when the
// mean is at or above threshold_dry. One item is taken every cycle while
// in_stall is low; a result passes three register stages (cell chain and
// sum, then the reciprocal multiply that divides by WINDOW_LEN, then the
// classifier) before it is offered on out_valid.
// After reset the window holds zeros, so feed WINDOW_LEN warm-up items before
// trusting the status. Write the thresholds only while no item is in flight.
module rain_level_hysteresis_detector #(
	parameter int WINDOW_LEN = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  rlhd_pkg::cfg_index_t       cfg_index,
	input  logic [rlhd_pkg::FIELD_W-1:0] cfg_data,
	// input items
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [rlhd_pkg::FIELD_W-1:0] charge_time,
	// result items
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rlhd_pkg::STATUS_W-1:0] status,
	output logic [rlhd_pkg::FIELD_W-1:0] average_time,
	output logic                       rain_indicator
);

	// Window sum width and divide-by-WINDOW_LEN reciprocal, fixed at elaboration.
	// floor(sum * RECIP / 2^SHIFT) equals floor(sum / WINDOW_LEN) for every sum
	// below 2^SUM_W, since the rounding error of RECIP times the sum stays below
	// 2^SHIFT.
	localparam int LOG_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 0;
	localparam int SUM_W   = rlhd_pkg::FIELD_W + LOG_W;
	localparam int SHIFT   = SUM_W + LOG_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
		((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

	// Configuration registers
	rlhd_pkg::thresholds_t thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.rain <= rlhd_pkg::THRESHOLD_RAIN_RESET;
			thr_q.dry  <= rlhd_pkg::THRESHOLD_DRY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rlhd_pkg::REG_THRESHOLD_RAIN: thr_q.rain <= cfg_data;
				rlhd_pkg::REG_THRESHOLD_DRY:  thr_q.dry  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow: each stage moves on when the one after it is empty or
	// moving, so bubbles close up while the output waits.
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic ready_s1;
	logic ready_s2;
	logic ready_s3;
	logic accept;

	assign ready_s3  = !valid_s3 || !out_stall;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_stall  = !ready_s1;
	assign accept    = in_valid && ready_s1;
	assign out_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 1: window of cells. The newest sample enters the first cell and
	// every cell hands its sample to the next; the last cell holds the oldest,
	// which is the one dropped from the sum.
	rlhd_pkg::field_t cell_out [WINDOW_LEN];

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_LEN; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				rlhd_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.shift      (accept),
					.sample_in  (charge_time),
					.sample_out (cell_out[gi])
				);
			end else begin : g_body
				rlhd_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.shift      (accept),
					.sample_in  (cell_out[gi-1]),
					.sample_out (cell_out[gi])
				);
			end
		end
	endgenerate

	// Running sum of the window; it doubles as the stage 1 payload, since it
	// only moves when a new item enters and stage 1 is free.
	logic [SUM_W-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept) begin
			sum_q <= sum_q - SUM_W'(cell_out[WINDOW_LEN-1]) + SUM_W'(charge_time);
		end
	end

	// Stage 2: divide by WINDOW_LEN through the reciprocal, keep the quotient.
	logic [PROD_W-1:0] product;
	rlhd_pkg::field_t  avg_s2;

	assign product = PROD_W'(sum_q) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			avg_s2 <= product[SHIFT +: rlhd_pkg::FIELD_W];
		end
	end

	// Stage 3: classify and hold the result for the output.
	rlhd_classify u_classify (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (ready_s3 && valid_s2),
		.average_in     (avg_s2),
		.thr            (thr_q),
		.status         (status),
		.average_time   (average_time),
		.rain_indicator (rain_indicator)
	);

endmodule

// ----- sv/rlhd_cell.sv -----
`timescale 1ns / 1ps

// One slot of the sample window: take the neighbour's sample on each shift.
module rlhd_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  rlhd_pkg::field_t sample_in,
	output rlhd_pkg::field_t sample_out
);

	rlhd_pkg::field_t sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= sample_in;
		end
	end

	assign sample_out = sample_q;

endmodule

// ----- sv/rlhd_classify.sv -----
`timescale 1ns / 1ps

// Classify the average against the thresholds and hold the wet flag.
module rlhd_classify (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  rlhd_pkg::field_t      average_in,
	input  rlhd_pkg::thresholds_t thr,
	output rlhd_pkg::status_t     status,
	output rlhd_pkg::field_t      average_time,
	output logic                  rain_indicator
);

	logic              wet_q;
	rlhd_pkg::status_t status_s3;
	rlhd_pkg::field_t  average_s3;
	logic              indicator_s3;

	logic              below_dry;
	logic              start_rain;
	logic              wet_mid;
	logic              end_rain;
	logic              wet_next;
	rlhd_pkg::status_t status_next;

	always_comb begin
		below_dry  = (average_in < thr.dry);
		start_rain = (average_in > thr.rain) && !wet_q;
		wet_mid    = wet_q || start_rain;
		end_rain   = below_dry && wet_mid;
		wet_next   = wet_mid && !end_rain;
		if (end_rain) begin
			status_next = rlhd_pkg::STATUS_ENDED;
		end else if (start_rain) begin
			status_next = rlhd_pkg::STATUS_STARTED;
		end else if (below_dry) begin
			status_next = rlhd_pkg::STATUS_DRY;
		end else begin
			status_next = rlhd_pkg::STATUS_RAINING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_q <= 1'b0;
		end else if (load) begin
			wet_q <= wet_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_s3    <= status_next;
			average_s3   <= average_in;
			indicator_s3 <= !below_dry;
		end
	end

	assign status         = status_s3;
	assign average_time   = average_s3;
	assign rain_indicator = indicator_s3;

endmodule
